### sv/vfiv_pkg.sv
// Shared types, constants and helpers for the vortex filament velocity block.
// No dependencies; every other file refers to this package by scoped names.
package vfiv_pkg;

  localparam int unsigned JOB_N_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIRCULATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_RADIUS = 2'd1;

  localparam logic signed [31:0] CIRC_RST = 32'sd65536;
  localparam logic [30:0]        CORE_RST = 31'd6554;

  // 1/(4 pi) in unsigned Q0.32
  localparam logic [31:0] INV_4PI_Q32 = 32'd341782638;
  // Largest term magnitude, 2^56 - 1
  localparam logic [63:0] TERM_LIM = 64'h00FF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [5:0]         point_index;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } coord3_t;

  // One closed filament waiting for the back end
  typedef struct packed {
    logic               bank;
    logic [JOB_N_W-1:0] n;
  } job_t;

  // Back end tells the front end that a bank is free again
  typedef struct packed {
    logic done;
    logic bank;
  } bk_status_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RD_I,
    B_RD_J,
    B_RD_K,
    B_GEOM,
    B_SQ,
    B_SQRT,
    B_DEN,
    B_CROSS,
    B_DIVI,
    B_DIV,
    B_ACC,
    B_NEXT,
    B_FIN,
    B_OUT
  } back_state_e;

  // Saturate a difference to +-(2^31 - 1)
  function automatic logic signed [31:0] clamp_comp(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sd2147483647;
    end else if (v < -34'sd2147483647) begin
      r = -32'sd2147483647;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### sv/vfiv_front.sv
// Front end: takes filament points, writes them to the point store and
// queues a job when a filament closes. Depends on vfiv_pkg.
module vfiv_front #(
  parameter int unsigned MAX_POINTS = 64,
  localparam int unsigned IDX_W = $clog2(MAX_POINTS),
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  vfiv_pkg::point_t     point_i,
  input  vfiv_pkg::bk_status_t status_i,
  output logic                 busy_o,
  output logic                 wr_en_o,
  output logic [IDX_W:0]       wr_addr_o,
  output vfiv_pkg::coord3_t    wr_data_o,
  output logic                 push_o,
  output vfiv_pkg::job_t       job_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fill_bank_q, fill_bank_d;
  logic [1:0]       bank_busy_q, bank_busy_d;
  logic             accept, room;
  logic [CNT_W-1:0] n_next;

  assign busy_o = bank_busy_q[fill_bank_q];
  assign accept = start_i & ~busy_o;
  assign room   = cnt_q < CNT_W'(MAX_POINTS);

  // store write, points beyond the bound are dropped
  assign wr_en_o        = accept & room;
  assign wr_addr_o      = {fill_bank_q, cnt_q[IDX_W-1:0]};
  assign wr_data_o.x    = point_i.point_x;
  assign wr_data_o.y    = point_i.point_y;
  assign wr_data_o.z    = point_i.point_z;

  assign n_next   = room ? cnt_q + CNT_W'(1) : cnt_q;
  assign push_o   = accept & point_i.last_point;
  assign job_o.bank = fill_bank_q;
  assign job_o.n    = vfiv_pkg::JOB_N_W'(n_next);

  // fill count, bank select and bank ownership
  always_comb begin
    cnt_d       = cnt_q;
    fill_bank_d = fill_bank_q;
    bank_busy_d = bank_busy_q;
    if (status_i.done) begin
      bank_busy_d[status_i.bank] = 1'b0;
    end
    if (push_o) begin
      cnt_d                    = '0;
      fill_bank_d              = ~fill_bank_q;
      bank_busy_d[fill_bank_q] = 1'b1;
    end else if (wr_en_o) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fill_bank_q <= 1'b0;
      bank_busy_q <= '0;
    end else begin
      cnt_q       <= cnt_d;
      fill_bank_q <= fill_bank_d;
      bank_busy_q <= bank_busy_d;
    end
  end

endmodule

### sv/vfiv_jobq.sv
// Two-entry job queue between front and back end.
// Depends on vfiv_pkg for the job type.
module vfiv_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vfiv_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           valid_o,
  output vfiv_pkg::job_t job_o,
  output logic           full_o
);

  vfiv_pkg::job_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign job_o   = slot_q[rd_ptr_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### sv/vfiv_back.sv
// Back end: holds the double-banked point store and runs the pairwise
// Biot-Savart sum with one shared multiplier, a square root and three dividers.
// Depends on vfiv_pkg.
module vfiv_back #(
  parameter int unsigned MAX_POINTS = 64,
  localparam int unsigned IDX_W = $clog2(MAX_POINTS),
  localparam int unsigned DEPTH = 2 ** (IDX_W + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  vfiv_pkg::job_t       job_i,
  output logic                 pop_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W:0]       wr_addr_i,
  input  vfiv_pkg::coord3_t    wr_data_i,
  input  logic signed [31:0]   circulation_i,
  input  logic [30:0]          core_radius_i,
  output vfiv_pkg::bk_status_t status_o,
  output logic                 res_valid_o,
  output vfiv_pkg::result_t    res_o
);

  // control
  vfiv_pkg::back_state_e state_q, state_d;
  logic [5:0]            step_q, step_d;
  logic [IDX_W-1:0]      i_q, i_d, j_q, j_d, k_idx;
  logic [1:0]            comp_q, comp_d;
  vfiv_pkg::job_t        job_q, job_d;
  logic                  res_valid_q;
  logic                  i_last, j_last, done;
  logic [IDX_W:0]        rd_addr;

  // point store and read data
  vfiv_pkg::coord3_t store_mem [DEPTH];
  vfiv_pkg::coord3_t rd_q, pi_q, pj_q;

  // geometry
  logic signed [31:0] pi_c [3], pj_c [3], pk_c [3];
  logic signed [32:0] msum [3], mid [3];
  logic signed [31:0] dl_n [3], r_n [3], dl_q [3], r_q [3];

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;

  // squared distance and square root
  logic [63:0] d2_q, d2_sum, sq_src_q;
  logic [33:0] sq_rem_q, sq_rem_n;
  logic [31:0] root_q, root_n;
  logic [35:0] sq_trial, sq_cmp;
  logic [95:0] den_q;

  // cross products, divider, sums
  logic signed [63:0] c_q [3], sum_q [3], term_s [3];
  logic [63:0]        cmag [3], tmag [3];
  logic [96:0]        drem_q [3], drem_t [3], drem_n [3];
  logic [55:0]        dnum_q [3], quo_q [3];
  logic               dsat_q [3], dfit [3];

  // final scaling
  logic [95:0]        m_q;
  logic [127:0]       t_q;
  logic signed [63:0] fsum;
  logic [63:0]        smag, fv;
  logic [31:0]        circ_mag, v32, vel_n;
  logic               fneg, fover;
  logic signed [31:0] vel_q [3];

  assign i_last = vfiv_pkg::JOB_N_W'(i_q) == job_q.n - vfiv_pkg::JOB_N_W'(1);
  assign j_last = vfiv_pkg::JOB_N_W'(j_q) == job_q.n - vfiv_pkg::JOB_N_W'(1);
  assign k_idx  = j_last ? '0 : j_q + IDX_W'(1);

  assign status_o.done = done;
  assign status_o.bank = job_q.bank;
  assign res_valid_o   = res_valid_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    i_d     = i_q;
    j_d     = j_q;
    comp_d  = comp_q;
    job_d   = job_q;
    pop_o   = 1'b0;
    done    = 1'b0;
    rd_addr = {job_q.bank, i_q};
    case (state_q)
      vfiv_pkg::B_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          i_d     = '0;
          j_d     = '0;
          state_d = vfiv_pkg::B_RD_I;
        end
      end
      vfiv_pkg::B_RD_I: state_d = vfiv_pkg::B_RD_J;
      vfiv_pkg::B_RD_J: begin
        rd_addr = {job_q.bank, j_q};
        state_d = vfiv_pkg::B_RD_K;
      end
      vfiv_pkg::B_RD_K: begin
        rd_addr = {job_q.bank, k_idx};
        state_d = vfiv_pkg::B_GEOM;
      end
      vfiv_pkg::B_GEOM: begin
        step_d  = '0;
        state_d = vfiv_pkg::B_SQ;
      end
      vfiv_pkg::B_SQ: begin
        if (step_q == 6'd4) begin
          step_d  = '0;
          state_d = (d2_sum == 64'd0) ? vfiv_pkg::B_NEXT : vfiv_pkg::B_SQRT;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      vfiv_pkg::B_SQRT: begin
        if (step_q == 6'd31) begin
          step_d  = '0;
          state_d = vfiv_pkg::B_DEN;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      vfiv_pkg::B_DEN: begin
        if (step_q == 6'd2) begin
          step_d  = '0;
          state_d = vfiv_pkg::B_CROSS;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      vfiv_pkg::B_CROSS: begin
        if (step_q == 6'd6) begin
          step_d  = '0;
          state_d = vfiv_pkg::B_DIVI;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      vfiv_pkg::B_DIVI: state_d = vfiv_pkg::B_DIV;
      vfiv_pkg::B_DIV: begin
        if (step_q == 6'd55) begin
          step_d  = '0;
          state_d = vfiv_pkg::B_ACC;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      vfiv_pkg::B_ACC: state_d = vfiv_pkg::B_NEXT;
      vfiv_pkg::B_NEXT: begin
        if (j_last) begin
          comp_d  = 2'd0;
          step_d  = '0;
          state_d = vfiv_pkg::B_FIN;
        end else begin
          j_d     = j_q + IDX_W'(1);
          state_d = vfiv_pkg::B_RD_I;
        end
      end
      vfiv_pkg::B_FIN: begin
        if (step_q == 6'd7) begin
          step_d = '0;
          if (comp_q == 2'd2) begin
            state_d = vfiv_pkg::B_OUT;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      vfiv_pkg::B_OUT: begin
        if (i_last) begin
          done    = 1'b1;
          state_d = vfiv_pkg::B_IDLE;
        end else begin
          i_d     = i_q + IDX_W'(1);
          j_d     = '0;
          state_d = vfiv_pkg::B_RD_I;
        end
      end
      default: state_d = vfiv_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vfiv_pkg::B_IDLE;
      step_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      comp_q      <= '0;
      job_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      i_q         <= i_d;
      j_q         <= j_d;
      comp_q      <= comp_d;
      job_q       <= job_d;
      res_valid_q <= state_q == vfiv_pkg::B_OUT;
    end
  end

  // point store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= store_mem[rd_addr];
  end

  // segment vector and midpoint offset
  assign pi_c[0] = pi_q.x;
  assign pi_c[1] = pi_q.y;
  assign pi_c[2] = pi_q.z;
  assign pj_c[0] = pj_q.x;
  assign pj_c[1] = pj_q.y;
  assign pj_c[2] = pj_q.z;
  assign pk_c[0] = rd_q.x;
  assign pk_c[1] = rd_q.y;
  assign pk_c[2] = rd_q.z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      msum[c] = 33'(pk_c[c]) + 33'(pj_c[c]);
      // halve, truncating toward zero
      mid[c]  = msum[c][32] ? ((msum[c] + 33'sd1) >>> 1) : (msum[c] >>> 1);
      dl_n[c] = vfiv_pkg::clamp_comp(34'(pk_c[c]) - 34'(pj_c[c]));
      r_n[c]  = vfiv_pkg::clamp_comp(34'(pi_c[c]) - 34'(mid[c]));
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      vfiv_pkg::B_SQ: begin
        case (step_q)
          6'd0:    begin mul_a = 33'(r_q[0]); mul_b = 33'(r_q[0]); end
          6'd1:    begin mul_a = 33'(r_q[1]); mul_b = 33'(r_q[1]); end
          6'd2:    begin mul_a = 33'(r_q[2]); mul_b = 33'(r_q[2]); end
          6'd3:    begin mul_a = {2'b00, core_radius_i}; mul_b = {2'b00, core_radius_i}; end
          default: ;
        endcase
      end
      vfiv_pkg::B_DEN: begin
        case (step_q)
          6'd0:    begin mul_a = {1'b0, d2_q[31:0]};  mul_b = {1'b0, root_q}; end
          6'd1:    begin mul_a = {1'b0, d2_q[63:32]}; mul_b = {1'b0, root_q}; end
          default: ;
        endcase
      end
      vfiv_pkg::B_CROSS: begin
        case (step_q)
          6'd0:    begin mul_a = 33'(dl_q[1]); mul_b = 33'(r_q[2]); end
          6'd1:    begin mul_a = 33'(dl_q[2]); mul_b = 33'(r_q[1]); end
          6'd2:    begin mul_a = 33'(dl_q[2]); mul_b = 33'(r_q[0]); end
          6'd3:    begin mul_a = 33'(dl_q[0]); mul_b = 33'(r_q[2]); end
          6'd4:    begin mul_a = 33'(dl_q[0]); mul_b = 33'(r_q[1]); end
          6'd5:    begin mul_a = 33'(dl_q[1]); mul_b = 33'(r_q[0]); end
          default: ;
        endcase
      end
      vfiv_pkg::B_FIN: begin
        case (step_q)
          6'd0:    begin mul_a = {1'b0, smag[31:0]};  mul_b = {1'b0, circ_mag}; end
          6'd1:    begin mul_a = {1'b0, smag[63:32]}; mul_b = {1'b0, circ_mag}; end
          6'd3:    begin mul_a = {1'b0, m_q[31:0]};   mul_b = {1'b0, vfiv_pkg::INV_4PI_Q32}; end
          6'd4:    begin mul_a = {1'b0, m_q[63:32]};  mul_b = {1'b0, vfiv_pkg::INV_4PI_Q32}; end
          6'd5:    begin mul_a = {1'b0, m_q[95:64]};  mul_b = {1'b0, vfiv_pkg::INV_4PI_Q32}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign d2_sum = d2_q + mul_q[63:0];

  // one root bit per cycle
  assign sq_trial = {sq_rem_q, sq_src_q[63:62]};
  assign sq_cmp   = {2'b00, root_q, 2'b01};
  always_comb begin
    if (sq_trial >= sq_cmp) begin
      sq_rem_n = 34'(sq_trial - sq_cmp);
      root_n   = {root_q[30:0], 1'b1};
    end else begin
      sq_rem_n = 34'(sq_trial);
      root_n   = {root_q[30:0], 1'b0};
    end
  end

  // three restoring dividers sharing the denominator
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cmag[c]   = c_q[c][63] ? (~c_q[c] + 64'd1) : c_q[c];
      drem_t[c] = {drem_q[c][95:0], dnum_q[c][55]};
      dfit[c]   = drem_t[c] >= {1'b0, den_q};
      drem_n[c] = dfit[c] ? drem_t[c] - {1'b0, den_q} : drem_t[c];
      tmag[c]   = dsat_q[c] ? vfiv_pkg::TERM_LIM : {8'b0, quo_q[c]};
      term_s[c] = c_q[c][63] ? (~tmag[c] + 64'd1) : tmag[c];
    end
  end

  // scale by circulation / (4 pi) and saturate
  always_comb begin
    case (comp_q)
      2'd1:    fsum = sum_q[1];
      2'd2:    fsum = sum_q[2];
      default: fsum = sum_q[0];
    endcase
    smag     = fsum[63] ? (~fsum + 64'd1) : fsum;
    circ_mag = circulation_i[31] ? (~circulation_i + 32'd1) : circulation_i;
    fneg     = fsum[63] ^ circulation_i[31];
    fv       = t_q[111:48];
    fover    = (|t_q[127:112]) || (fv > (fneg ? 64'h8000_0000 : 64'h7FFF_FFFF));
    v32      = fover ? (fneg ? 32'h8000_0000 : 32'h7FFF_FFFF) : fv[31:0];
    vel_n    = fneg ? (~v32 + 32'd1) : v32;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (state_q)
      vfiv_pkg::B_IDLE: begin
        for (int c = 0; c < 3; c++) sum_q[c] <= '0;
      end
      vfiv_pkg::B_RD_J: pi_q <= rd_q;
      vfiv_pkg::B_RD_K: pj_q <= rd_q;
      vfiv_pkg::B_GEOM: begin
        for (int c = 0; c < 3; c++) begin
          dl_q[c] <= dl_n[c];
          r_q[c]  <= r_n[c];
        end
      end
      vfiv_pkg::B_SQ: begin
        if (step_q == 6'd0) begin
          d2_q <= '0;
        end else begin
          d2_q <= d2_sum;
        end
        if (step_q == 6'd4) begin
          sq_src_q <= d2_sum;
          sq_rem_q <= '0;
          root_q   <= '0;
        end
      end
      vfiv_pkg::B_SQRT: begin
        sq_rem_q <= sq_rem_n;
        root_q   <= root_n;
        sq_src_q <= sq_src_q << 2;
      end
      vfiv_pkg::B_DEN: begin
        if (step_q == 6'd1) begin
          den_q <= {32'b0, mul_q[63:0]};
        end else if (step_q == 6'd2) begin
          den_q <= den_q + {mul_q[63:0], 32'b0};
        end
      end
      vfiv_pkg::B_CROSS: begin
        case (step_q)
          6'd1:    c_q[0] <= mul_q[63:0];
          6'd2:    c_q[0] <= c_q[0] - mul_q[63:0];
          6'd3:    c_q[1] <= mul_q[63:0];
          6'd4:    c_q[1] <= c_q[1] - mul_q[63:0];
          6'd5:    c_q[2] <= mul_q[63:0];
          6'd6:    c_q[2] <= c_q[2] - mul_q[63:0];
          default: ;
        endcase
      end
      vfiv_pkg::B_DIVI: begin
        // quotient of 2^56 or more saturates
        for (int c = 0; c < 3; c++) begin
          drem_q[c] <= {57'b0, cmag[c][63:24]};
          dsat_q[c] <= {57'b0, cmag[c][63:24]} >= {1'b0, den_q};
          dnum_q[c] <= {cmag[c][23:0], 32'b0};
          quo_q[c]  <= '0;
        end
      end
      vfiv_pkg::B_DIV: begin
        for (int c = 0; c < 3; c++) begin
          drem_q[c] <= drem_n[c];
          quo_q[c]  <= {quo_q[c][54:0], dfit[c]};
          dnum_q[c] <= dnum_q[c] << 1;
        end
      end
      vfiv_pkg::B_ACC: begin
        for (int c = 0; c < 3; c++) sum_q[c] <= sum_q[c] + term_s[c];
      end
      vfiv_pkg::B_FIN: begin
        case (step_q)
          6'd1:    m_q <= {32'b0, mul_q[63:0]};
          6'd2:    m_q <= m_q + {mul_q[63:0], 32'b0};
          6'd4:    t_q <= {64'b0, mul_q[63:0]};
          6'd5:    t_q <= t_q + {32'b0, mul_q[63:0], 32'b0};
          6'd6:    t_q <= t_q + {mul_q[63:0], 64'b0};
          6'd7: begin
            case (comp_q)
              2'd1:    vel_q[1] <= vel_n;
              2'd2:    vel_q[2] <= vel_n;
              default: vel_q[0] <= vel_n;
            endcase
          end
          default: ;
        endcase
      end
      vfiv_pkg::B_OUT: begin
        res_o.point_index <= 6'(i_q);
        res_o.vel_x       <= vel_q[0];
        res_o.vel_y       <= vel_q[1];
        res_o.vel_z       <= vel_q[2];
        res_o.last_result <= i_last;
        for (int c = 0; c < 3; c++) sum_q[c] <= '0;
      end
      default: ;
    endcase
  end

endmodule

### sv/vortex_filament_induced_velocity.sv
// Top level of the vortex filament induced velocity block: configuration
// registers, front end, job queue and back end. Depends on vfiv_pkg and
// vfiv_front, vfiv_jobq, vfiv_back.
//
//  channel   direction  handshake                  payload
//  point     in         start & !busy              point_i (point_t)
//  result    out        res_valid_o, one cycle     res_o (result_t)
//  config    in         cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// A closing point queues that filament for the back end. For each
// segment-point pair the 56-step divider and the 32-step square root
// dominate the work, and a pair whose distance term is zero skips both;
// each result then passes through the final scaling. The store is double
// banked: busy is high only while the bank being filled still belongs to
// an unfinished filament. Results cannot be held off. Reset clears control
// state; the store needs no clearing.
module vortex_filament_induced_velocity #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  vfiv_pkg::point_t             point_i,
  output logic                         res_valid_o,
  output vfiv_pkg::result_t            res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [vfiv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);

  logic signed [31:0]   circulation_q;
  logic [30:0]          core_radius_q;
  logic                 wr_en;
  logic [IDX_W:0]       wr_addr;
  vfiv_pkg::coord3_t    wr_data;
  logic                 job_push, job_pop, job_valid, jq_full;
  vfiv_pkg::job_t       job_in, job_head;
  vfiv_pkg::bk_status_t bk_status;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circulation_q <= vfiv_pkg::CIRC_RST;
      core_radius_q <= vfiv_pkg::CORE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        vfiv_pkg::REG_CIRCULATION: circulation_q <= cfg_data_i;
        vfiv_pkg::REG_CORE_RADIUS: core_radius_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  vfiv_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .point_i   (point_i),
    .status_i  (bk_status),
    .busy_o    (busy),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (job_push),
    .job_o     (job_in)
  );

  vfiv_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_head),
    .full_o  (jq_full)
  );

  vfiv_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_head),
    .pop_o         (job_pop),
    .wr_en_i       (wr_en),
    .wr_addr_i     (wr_addr),
    .wr_data_i     (wr_data),
    .circulation_i (circulation_q),
    .core_radius_i (core_radius_q),
    .status_o      (bk_status),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o)
  );

  // bank ownership keeps the queue from overflowing
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !jq_full)
    else $error("job queued while queue full");

  // a bank is released as the last result of its filament is registered
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.done |=> res_valid_o && res_o.last_result)
    else $error("bank released without final result");

  // results are never issued on consecutive cycles
  a_res_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("back-to-back result strobes");

endmodule
